FILE: hw/rtl/msr_pkg.sv
`default_nettype none

package msr_pkg;

  // Field widths of the item and result payloads.
  localparam int unsigned ModeW   = 2;
  localparam int unsigned MotorW  = 2;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned AccelW  = 11;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  // Motor count is fixed by the shared-timer pairing of motors 2 and 3.
  localparam int unsigned NumMotors = 4;

  // Default tick rate of the ramp update in Hz.
  localparam int unsigned TICK_RATE_HZ_DEF = 1000;

  // Acceleration saturation limits in rpm per second.
  localparam int unsigned ACCEL_LOW  = 10;
  localparam int unsigned ACCEL_HIGH = 2000;

  // Register reset values.
  localparam logic [AccelW-1:0] AccelRst    = AccelW'(1000);
  localparam logic [SpeedW-1:0] MinSpeedRst = SpeedW'(10);
  localparam logic [SpeedW-1:0] MaxSpeedRst = SpeedW'(1000);

  // Item kinds.
  typedef enum logic [ModeW-1:0] {
    MODE_TICK = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_SOFT = 2'd2,
    MODE_HALT = 2'd3
  } mode_e;

  // Motion phase of one motor.
  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_ACCEL   = 2'd1,
    PH_RUN     = 2'd2,
    PH_DECEL   = 2'd3
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    REG_ACCEL0 = 3'd0,
    REG_ACCEL1 = 3'd1,
    REG_ACCEL2 = 3'd2,
    REG_ACCEL3 = 3'd3,
    REG_MIN    = 3'd4,
    REG_MAX    = 3'd5
  } reg_idx_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_LOAD  = 2'd1,
    ST_MUL   = 2'd2,
    ST_WRITE = 2'd3
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load;
    logic mul;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/msr_ctrl.sv
`default_nettype none

module msr_ctrl
  import msr_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The output register can take a new result when it is empty or drains now.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid flag: set on commit, cleared when the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/msr_datapath.sv
`default_nettype none

module msr_datapath
  import msr_pkg::*;
#(
  parameter int unsigned TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [CfgAddrW-1:0]  cfg_addr_i,
  input  wire  [CfgDataW-1:0]  cfg_wdata_i,
  input  wire  [ModeW-1:0]     mode_i,
  input  wire  [MotorW-1:0]    motor_i,
  input  wire  [SpeedW-1:0]    speed_req_i,
  input  wire                  dir_req_i,
  input  cmd_t                 cmd_i,
  output logic [OutDataW-1:0]  out_data_o
);

  // Divider count stays below TICK_RATE_HZ / ACCEL_LOW.
  localparam int unsigned DivW     = $clog2(TICK_RATE_HZ / ACCEL_LOW);
  // Largest step per tick is ACCEL_HIGH / TICK_RATE_HZ, and at least one.
  localparam int unsigned StepW    = $clog2(ACCEL_HIGH / TICK_RATE_HZ + 2);
  // Reciprocal of the tick rate, exact for every accel up to ACCEL_HIGH.
  localparam int unsigned RecShift = $clog2(ACCEL_HIGH * TICK_RATE_HZ);
  localparam int unsigned Recip    = ((2 ** RecShift) + TICK_RATE_HZ - 1) / TICK_RATE_HZ;
  localparam int unsigned MulW     = RecShift + StepW;
  localparam int unsigned DprodW   = DivW + 1 + AccelW;

  // Configuration registers.
  logic [AccelW-1:0] accel_q [NumMotors];
  logic [SpeedW-1:0] min_speed_q;
  logic [SpeedW-1:0] max_speed_q;

  // Per-motor state.
  logic [SpeedW-1:0] cur_speed_q [NumMotors];
  logic [SpeedW-1:0] tgt_speed_q [NumMotors];
  logic              stop_pend_q [NumMotors];
  phase_e            phase_q     [NumMotors];
  logic              dir_bit_q   [NumMotors];
  logic [DivW-1:0]   tick_div_q  [NumMotors];
  logic              active_q    [NumMotors];

  // Captured item.
  mode_e             mode_q;
  logic [MotorW-1:0] motor_q;
  logic [SpeedW-1:0] req_q;
  logic              dir_req_q;

  // Operands read for the addressed motor.
  logic [AccelW-1:0] accel_sat_q, accel_sat_d;
  logic              accel_ge_q;
  logic [SpeedW-1:0] lo_q, lo_d, hi_d;
  logic [SpeedW-1:0] treq_q, treq_d;
  logic              blocked_q;
  logic [SpeedW-1:0] cur_q, tgt_q;
  logic              stop_q, act_q, dirb_q;
  phase_e            ph_q;
  logic [DivW-1:0]   div_q;

  // Products.
  logic [MulW-1:0]   prod_q;
  logic              due_q;
  logic [DprodW-1:0] dprod;

  // Results of the update.
  logic [SpeedW-1:0] n_cur, n_tgt, next_speed, step16;
  logic              n_stop, n_act, n_dir, changed, refused, halt, moved;
  phase_e            n_ph;
  logic [DivW-1:0]   n_div;
  logic [OutDataW-1:0] out_q;

  // Configuration writes; writes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMotors; i++) begin
        accel_q[i] <= AccelRst;
      end
      min_speed_q <= MinSpeedRst;
      max_speed_q <= MaxSpeedRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_ACCEL0: accel_q[0]  <= cfg_wdata_i[AccelW-1:0];
        REG_ACCEL1: accel_q[1]  <= cfg_wdata_i[AccelW-1:0];
        REG_ACCEL2: accel_q[2]  <= cfg_wdata_i[AccelW-1:0];
        REG_ACCEL3: accel_q[3]  <= cfg_wdata_i[AccelW-1:0];
        REG_MIN:    min_speed_q <= cfg_wdata_i;
        REG_MAX:    max_speed_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // Item capture at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q    <= mode_e'(mode_i);
      motor_q   <= motor_i;
      req_q     <= speed_req_i;
      dir_req_q <= dir_req_i;
    end
  end

  // Operand preparation: saturate accel, clamp request, check the timer partner.
  always_comb begin
    accel_sat_d = accel_q[motor_q];
    if (32'(accel_sat_d) < ACCEL_LOW) begin
      accel_sat_d = AccelW'(ACCEL_LOW);
    end
    if (32'(accel_sat_d) > ACCEL_HIGH) begin
      accel_sat_d = AccelW'(ACCEL_HIGH);
    end
    lo_d   = (min_speed_q == '0) ? SpeedW'(1) : min_speed_q;
    hi_d   = (max_speed_q == '0) ? SpeedW'(1) : max_speed_q;
    treq_d = (req_q < lo_d) ? lo_d : req_q;
    if (treq_d > hi_d) begin
      treq_d = hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      accel_sat_q <= accel_sat_d;
      accel_ge_q  <= (32'(accel_sat_d) >= TICK_RATE_HZ);
      lo_q        <= lo_d;
      treq_q      <= treq_d;
      blocked_q   <= motor_q[1] && (phase_q[motor_q ^ MotorW'(1)] != PH_STOPPED);
      cur_q       <= cur_speed_q[motor_q];
      tgt_q       <= tgt_speed_q[motor_q];
      stop_q      <= stop_pend_q[motor_q];
      ph_q        <= phase_q[motor_q];
      div_q       <= tick_div_q[motor_q];
      act_q       <= active_q[motor_q];
      dirb_q      <= dir_bit_q[motor_q];
    end
  end

  // Step by reciprocal multiply; divider is due once (count + 2) * accel > rate.
  assign dprod = DprodW'(DprodW'(div_q) + DprodW'(2)) * DprodW'(accel_sat_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= MulW'(accel_sat_q) * MulW'(Recip);
      due_q  <= (32'(dprod) > TICK_RATE_HZ);
    end
  end

  assign step16 = accel_ge_q ? SpeedW'(prod_q[RecShift +: StepW]) : SpeedW'(1);

  // State update for the addressed motor.
  always_comb begin
    n_cur      = cur_q;
    n_tgt      = tgt_q;
    n_stop     = stop_q;
    n_ph       = ph_q;
    n_div      = div_q;
    n_act      = act_q;
    n_dir      = dirb_q;
    next_speed = cur_q;
    changed    = 1'b0;
    refused    = 1'b0;
    halt       = 1'b0;
    moved      = 1'b0;
    case (mode_q)
      MODE_TICK: begin
        if (!stop_q && (tgt_q == '0) && (cur_q == '0)) begin
          // Idle motor: only the phase is settled.
          n_ph = PH_STOPPED;
        end else if (!accel_ge_q && !due_q) begin
          // Divider not yet due: count the tick.
          n_div = div_q + DivW'(1);
        end else begin
          if (!accel_ge_q) begin
            n_div = '0;
          end
          if (stop_q) begin
            if (cur_q > step16) begin
              next_speed = cur_q - step16;
              moved      = 1'b1;
            end else begin
              halt = 1'b1;
            end
          end else if (cur_q < tgt_q) begin
            moved = 1'b1;
            if ((tgt_q - cur_q) <= step16) begin
              next_speed = tgt_q;
              n_ph       = PH_RUN;
            end else begin
              next_speed = cur_q + step16;
              n_ph       = PH_ACCEL;
            end
          end else if (cur_q > tgt_q) begin
            moved = 1'b1;
            if ((cur_q - tgt_q) <= step16) begin
              next_speed = tgt_q;
              n_ph       = PH_RUN;
            end else begin
              next_speed = cur_q - step16;
              n_ph       = PH_DECEL;
            end
          end else begin
            n_ph = (tgt_q == '0) ? PH_STOPPED : PH_RUN;
          end
          if (moved) begin
            n_cur = next_speed;
            if (next_speed == '0) begin
              halt = 1'b1;
            end else begin
              changed = 1'b1;
            end
          end
        end
      end
      MODE_RUN: begin
        if (blocked_q) begin
          refused = 1'b1;
        end else begin
          n_dir  = dir_req_q;
          n_tgt  = treq_q;
          n_stop = 1'b0;
          if (cur_q == '0) begin
            n_cur   = lo_q;
            changed = 1'b1;
          end
          n_act = 1'b1;
          n_ph  = (n_cur < treq_q) ? PH_ACCEL : PH_RUN;
        end
      end
      MODE_SOFT: begin
        n_stop = 1'b1;
        n_ph   = PH_DECEL;
      end
      MODE_HALT: begin
        halt = 1'b1;
      end
      default: begin
        halt = 1'b1;
      end
    endcase
    // Halting clears the motor and turns its output off.
    if (halt) begin
      n_cur  = '0;
      n_tgt  = '0;
      n_ph   = PH_STOPPED;
      n_stop = 1'b0;
      n_act  = 1'b0;
    end
  end

  // Write-back of the motor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMotors; i++) begin
        cur_speed_q[i] <= '0;
        tgt_speed_q[i] <= '0;
        stop_pend_q[i] <= 1'b0;
        phase_q[i]     <= PH_STOPPED;
        dir_bit_q[i]   <= 1'b0;
        tick_div_q[i]  <= '0;
        active_q[i]    <= 1'b0;
      end
    end else if (cmd_i.commit) begin
      cur_speed_q[motor_q] <= n_cur;
      tgt_speed_q[motor_q] <= n_tgt;
      stop_pend_q[motor_q] <= n_stop;
      phase_q[motor_q]     <= n_ph;
      dir_bit_q[motor_q]   <= n_dir;
      tick_div_q[motor_q]  <= n_div;
      active_q[motor_q]    <= n_act;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= {refused, changed, n_act, n_dir, n_ph, n_cur, motor_q};
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/multi_stepper_speed_ramp.sv
`default_nettype none

// Channel   Direction  Signals                         Content
// s_axis    in         tvalid/tready/tdata/tuser       one command or tick item
// m_axis    out        tvalid/tready/tdata             one status result per item
// cfg       in         cfg_we_i/cfg_addr_i/cfg_wdata_i register write, no read-back
//
// Each item passes through four steps: accept, operand read, multiply, write-back.
// These steps run in order on one shared read/multiply/update path.
// The result register lets the next item be accepted while a result waits.
// A stalled output holds the controller in write-back until the result drains.
// Reset clears all motor state and loads the register defaults; no clearing pass.

module multi_stepper_speed_ramp
  import msr_pkg::*;
#(
  parameter int unsigned TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [CfgAddrW-1:0]  cfg_addr_i,
  input  wire  [CfgDataW-1:0]  cfg_wdata_i,
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // motor [1:0], speed_request [17:2], dir_request [18], zero [23:19]
  input  wire  [InDataW-1:0]   s_axis_tdata_i,
  // mode [1:0]
  input  wire  [ModeW-1:0]     s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  // motor_index [1:0], speed_now [17:2], motion_state [19:18], direction_out [20],
  // pulse_on [21], speed_changed [22], run_refused [23]
  output logic [OutDataW-1:0]  m_axis_tdata_o
);

  cmd_t cmd;

  msr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  msr_datapath #(
    .TICK_RATE_HZ (TICK_RATE_HZ)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (s_axis_tuser_i),
    .motor_i     (s_axis_tdata_i[1:0]),
    .speed_req_i (s_axis_tdata_i[17:2]),
    .dir_req_i   (s_axis_tdata_i[18]),
    .cmd_i       (cmd),
    .out_data_o  (m_axis_tdata_o)
  );

  // An accepted item keeps the input closed for the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted again right after acceptance");

  // A committed result is presented on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid_o)
    else $error("committed result not presented");

  // A stopped motor reports zero speed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[19:18] == PH_STOPPED))
      |-> (m_axis_tdata_o[17:2] == '0))
    else $error("stopped motor with nonzero speed");

  // A refused run never reprograms the step frequency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[23]) |-> !m_axis_tdata_o[22])
    else $error("refused run flagged as speed change");

endmodule

`default_nettype wire

FILE: tb/ramp_status_checker.sv
// Watches the register port and both item channels of the speed ramp block,
// predicts one status item per accepted command item and compares them in order.
module ramp_status_checker
  import msr_pkg::*;
#(
  parameter int unsigned TickRateHz = TICK_RATE_HZ_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgAddrW-1:0]  cfg_addr_i,
  input  wire [CfgDataW-1:0]  cfg_wdata_i,
  input  wire                 s_valid_i,
  input  wire                 s_ready_i,
  // motor [1:0], speed_request [17:2], dir_request [18], zero [23:19]
  input  wire [InDataW-1:0]   s_data_i,
  // mode [1:0]
  input  wire [ModeW-1:0]     s_mode_i,
  input  wire                 m_valid_i,
  input  wire                 m_ready_i,
  // motor_index [1:0], speed_now [17:2], motion_state [19:18], direction_out [20],
  // pulse_on [21], speed_changed [22], run_refused [23]
  input  wire [OutDataW-1:0]  m_data_i,
  output int                  err_cnt_o,
  output int                  pending_o
);

  // Status item laid out as on the result bus, lowest field last.
  typedef struct packed {
    logic              run_refused;
    logic              speed_changed;
    logic              pulse_on;
    logic              direction;
    phase_e            phase;
    logic [SpeedW-1:0] speed;
    logic [MotorW-1:0] motor;
  } status_t;

  // Register copy.
  logic [AccelW-1:0] accel_q [NumMotors];
  logic [SpeedW-1:0] min_q;
  logic [SpeedW-1:0] max_q;

  // Per-motor ramp state.
  logic [SpeedW-1:0] speed_q   [NumMotors];
  logic [SpeedW-1:0] target_q  [NumMotors];
  logic              stop_q    [NumMotors];
  phase_e            phase_q   [NumMotors];
  logic              dir_q     [NumMotors];
  logic [15:0]       divider_q [NumMotors];
  logic              active_q  [NumMotors];

  status_t status_due [$];

  // Drops a motor to standstill with its pulse output off.
  function automatic void halt_motor(int m);
    active_q[m] = 1'b0;
    speed_q[m]  = '0;
    target_q[m] = '0;
    phase_q[m]  = PH_STOPPED;
    stop_q[m]   = 1'b0;
  endfunction

  // One ramp update; returns 1 when the step frequency moves to a new nonzero rpm.
  function automatic logic ramp_tick(int m);
    int unsigned acc, stp, cur, tgt, nxt, every;
    if (!stop_q[m] && target_q[m] == 0 && speed_q[m] == 0) begin
      phase_q[m] = PH_STOPPED;
      return 1'b0;
    end
    acc = accel_q[m];
    if (acc < ACCEL_LOW) acc = ACCEL_LOW;
    if (acc > ACCEL_HIGH) acc = ACCEL_HIGH;
    if (acc >= TickRateHz) begin
      stp = acc / TickRateHz;
    end else begin
      // Slow ramps move one rpm per several ticks.
      every = TickRateHz / acc;
      divider_q[m] = divider_q[m] + 16'd1;
      if (divider_q[m] < every) return 1'b0;
      divider_q[m] = '0;
      stp = 1;
    end
    cur = speed_q[m];
    tgt = target_q[m];
    if (stop_q[m]) begin
      if (cur > stp) begin
        nxt = cur - stp;
      end else begin
        halt_motor(m);
        return 1'b0;
      end
    end else if (cur < tgt) begin
      phase_q[m] = PH_ACCEL;
      if (tgt - cur <= stp) begin
        nxt = tgt;
        phase_q[m] = PH_RUN;
      end else begin
        nxt = cur + stp;
      end
    end else if (cur > tgt) begin
      phase_q[m] = PH_DECEL;
      if (cur - tgt <= stp) begin
        nxt = tgt;
        phase_q[m] = PH_RUN;
      end else begin
        nxt = cur - stp;
      end
    end else begin
      phase_q[m] = (tgt == 0) ? PH_STOPPED : PH_RUN;
      return 1'b0;
    end
    speed_q[m] = nxt[SpeedW-1:0];
    if (nxt == 0) begin
      halt_motor(m);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one command item to the motor state and builds its status item.
  function automatic status_t predict_status(mode_e mode, logic [MotorW-1:0] motor,
                                             logic [SpeedW-1:0] request, logic dir);
    status_t st;
    int unsigned lo, hi, req;
    int m;
    m = motor;
    st = '0;
    case (mode)
      MODE_TICK: begin
        st.speed_changed = ramp_tick(m);
      end
      MODE_RUN: begin
        lo  = (min_q != 0) ? min_q : 1;
        hi  = (max_q != 0) ? max_q : 1;
        req = request;
        if (req < lo) req = lo;
        if (req > hi) req = hi;
        // Motors 2 and 3 share a timer: a run is refused until the partner has stopped.
        if (m >= 2 && phase_q[m ^ 1] != PH_STOPPED) begin
          st.run_refused = 1'b1;
        end else begin
          dir_q[m]    = dir;
          target_q[m] = req[SpeedW-1:0];
          stop_q[m]   = 1'b0;
          if (speed_q[m] == 0) begin
            speed_q[m] = lo[SpeedW-1:0];
            st.speed_changed = 1'b1;
          end
          active_q[m] = 1'b1;
          phase_q[m]  = (speed_q[m] < req) ? PH_ACCEL : PH_RUN;
        end
      end
      MODE_SOFT: begin
        stop_q[m]  = 1'b1;
        phase_q[m] = PH_DECEL;
      end
      default: begin
        halt_motor(m);
      end
    endcase
    st.motor     = motor;
    st.speed     = speed_q[m];
    st.phase     = phase_q[m];
    st.direction = dir_q[m];
    st.pulse_on  = active_q[m];
    return st;
  endfunction

  // Compare results first, then predict for the item accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    status_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < NumMotors; i++) begin
        accel_q[i]   = AccelRst;
        speed_q[i]   = '0;
        target_q[i]  = '0;
        stop_q[i]    = 1'b0;
        phase_q[i]   = PH_STOPPED;
        dir_q[i]     = 1'b0;
        divider_q[i] = '0;
        active_q[i]  = 1'b0;
      end
      min_q = MinSpeedRst;
      max_q = MaxSpeedRst;
      status_due.delete();
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_addr_i))
          REG_ACCEL0, REG_ACCEL1, REG_ACCEL2, REG_ACCEL3: begin
            accel_q[cfg_addr_i[1:0]] = cfg_wdata_i[AccelW-1:0];
          end
          REG_MIN: min_q = cfg_wdata_i;
          REG_MAX: max_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        got = status_t'(m_data_i);
        if (status_due.size() == 0) begin
          $error("status item with no command item outstanding: %h", m_data_i);
          err_cnt_o++;
        end else begin
          want = status_due.pop_front();
          if (got.motor != want.motor) begin
            $error("motor_index: expected %0d, got %0d", want.motor, got.motor);
            err_cnt_o++;
          end
          if (got.speed != want.speed) begin
            $error("speed_now: expected %0d, got %0d", want.speed, got.speed);
            err_cnt_o++;
          end
          if (got.phase != want.phase) begin
            $error("motion_state: expected %0d, got %0d", want.phase, got.phase);
            err_cnt_o++;
          end
          if (got.direction != want.direction) begin
            $error("direction_out: expected %0d, got %0d", want.direction, got.direction);
            err_cnt_o++;
          end
          if (got.pulse_on != want.pulse_on) begin
            $error("pulse_on: expected %0d, got %0d", want.pulse_on, got.pulse_on);
            err_cnt_o++;
          end
          if (got.speed_changed != want.speed_changed) begin
            $error("speed_changed: expected %0d, got %0d",
                   want.speed_changed, got.speed_changed);
            err_cnt_o++;
          end
          if (got.run_refused != want.run_refused) begin
            $error("run_refused: expected %0d, got %0d", want.run_refused, got.run_refused);
            err_cnt_o++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        status_due.push_back(predict_status(mode_e'(s_mode_i), s_data_i[1:0],
                                            s_data_i[17:2], s_data_i[18]));
      end
      pending_o = status_due.size();
    end
  end

endmodule

FILE: tb/tb.sv
module tb;
  import msr_pkg::*;

  localparam int CycleLimit = 600000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                s_valid;
  logic                s_ready;
  logic [InDataW-1:0]  s_data;
  logic [ModeW-1:0]    s_mode;
  logic                m_valid;
  logic                m_ready;
  logic [OutDataW-1:0] m_data;
  int                  err_cnt;
  int                  pending;
  int                  cycles = 0;
  logic                tx_calm = 1'b0;
  logic                rx_calm = 1'b0;

  always #1 clk_i = ~clk_i;

  multi_stepper_speed_ramp dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_mode),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  ramp_status_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .s_valid_i   (s_valid),
    .s_ready_i   (s_ready),
    .s_data_i    (s_data),
    .s_mode_i    (s_mode),
    .m_valid_i   (m_valid),
    .m_ready_i   (m_ready),
    .m_data_i    (m_data),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Register write, one cycle wide.
  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Loads all six registers, one write after another.
  task automatic load_regs(logic [CfgDataW-1:0] a0, logic [CfgDataW-1:0] a1,
                           logic [CfgDataW-1:0] a2, logic [CfgDataW-1:0] a3,
                           logic [CfgDataW-1:0] lo, logic [CfgDataW-1:0] hi);
    write_reg(REG_ACCEL0, a0);
    write_reg(REG_ACCEL1, a1);
    write_reg(REG_ACCEL2, a2);
    write_reg(REG_ACCEL3, a3);
    write_reg(REG_MIN, lo);
    write_reg(REG_MAX, hi);
  endtask

  // Offers one command item after a random gap, none when calm, and holds it until accepted.
  task automatic send_item(mode_e mode, logic [MotorW-1:0] motor,
                           logic [SpeedW-1:0] request, logic dir);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_mode  = mode;
    s_data  = {5'b0, dir, request, motor};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Waits until every status item has come back, then lets the block settle.
  task automatic drain();
    s_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Mostly ticks so ramps run their course, with runs and stops mixed in.
  task automatic random_items(int count);
    int sel, pick;
    mode_e mode;
    logic [SpeedW-1:0] request;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 40) == 0) tx_calm = ~tx_calm;
      sel = $urandom_range(0, 99);
      if (sel < 68) mode = MODE_TICK;
      else if (sel < 84) mode = MODE_RUN;
      else if (sel < 93) mode = MODE_SOFT;
      else mode = MODE_HALT;
      pick = $urandom_range(0, 9);
      if (pick < 6) request = SpeedW'($urandom_range(0, 80));
      else if (pick < 9) request = SpeedW'($urandom);
      else request = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      send_item(mode, MotorW'($urandom_range(0, 3)), request, 1'($urandom_range(0, 1)));
    end
  endtask

  // Result side: random stalls per item, with calm stretches.
  initial begin
    int gap;
    m_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 40) == 0) rx_calm = ~rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_ready = 1'b1;
      @(posedge clk_i);
      while (!m_valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Command side and verdict.
  initial begin
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_mode    = MODE_TICK;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at reset settings: clamps, shared timer, soft stop to rest.
    send_item(MODE_RUN, 2'd0, 16'd0, 1'b1);
    send_item(MODE_RUN, 2'd0, 16'hFFFF, 1'b0);
    send_item(MODE_TICK, 2'd0, 16'd0, 1'b0);
    send_item(MODE_TICK, 2'd1, 16'hFFFF, 1'b1);
    send_item(MODE_RUN, 2'd2, 16'd12, 1'b1);
    send_item(MODE_RUN, 2'd3, 16'd50, 1'b0);
    repeat (3) send_item(MODE_TICK, 2'd2, 16'd0, 1'b0);
    send_item(MODE_SOFT, 2'd2, 16'd0, 1'b0);
    repeat (12) send_item(MODE_TICK, 2'd2, 16'd0, 1'b0);
    send_item(MODE_RUN, 2'd3, 16'd50, 1'b1);
    send_item(MODE_HALT, 2'd3, 16'd0, 1'b0);
    send_item(MODE_SOFT, 2'd1, 16'd0, 1'b0);
    send_item(MODE_TICK, 2'd1, 16'd0, 1'b0);
    random_items(150);
    drain();

    // Fast ramps to low targets.
    load_regs(16'd2000, 16'd2000, 16'd2000, 16'd2000, 16'd1, 16'd40);
    random_items(200);
    drain();

    // Divided ticks at slow accelerations.
    load_regs(16'd10, 16'd500, 16'd999, 16'd1001, 16'd5, 16'd30);
    random_items(200);
    drain();

    // Saturated accelerations; zero limits act as one.
    load_regs(16'd0, 16'd2047, 16'd1000, 16'd333, 16'd0, 16'd0);
    random_items(150);
    drain();

    // Minimum above maximum.
    load_regs(16'd1500, 16'd9, 16'd2000, 16'd100, 16'd50, 16'd20);
    random_items(200);
    drain();

    // Top speed at both limits.
    load_regs(16'd2000, 16'd1999, 16'd11, 16'd1000, 16'hFFFF, 16'hFFFF);
    random_items(150);
    drain();

    // Full speed range with mixed accelerations.
    load_regs(CfgDataW'($urandom_range(0, 2047)), CfgDataW'($urandom_range(0, 2047)),
              CfgDataW'($urandom_range(10, 2000)), CfgDataW'($urandom_range(1000, 2047)),
              16'd1, 16'hFFFF);
    random_items(200);
    drain();

    // Back to reset values.
    load_regs(CfgDataW'(AccelRst), CfgDataW'(AccelRst), CfgDataW'(AccelRst),
              CfgDataW'(AccelRst), MinSpeedRst, MaxSpeedRst);
    random_items(150);
    drain();

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/msr_pkg.sv
hw/rtl/msr_ctrl.sv
hw/rtl/msr_datapath.sv
hw/rtl/multi_stepper_speed_ramp.sv
tb/ramp_status_checker.sv
tb/tb.sv
